// ===== hw/rtl/contiguous_unit_allocator_defines.svh =====
// Assertion macros shared by the contiguous unit allocator RTL.
`ifndef CONTIGUOUS_UNIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_UNIT_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CUA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CUA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cua_pkg.sv =====
// Package of shared codes and control types for the contiguous unit allocator.
`timescale 1ns / 1ps
package cua_pkg;

   // Operation codes of an incoming command word.
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_COMPACT = 2'd2;
   localparam logic [1:0] OP_READ    = 2'd3;

   // Placement policies for allocation.
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_NONE  = 2'd3;

   // Response status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;

   // Owner byte that marks a unit as free ('.').
   localparam logic [7:0] FREE_MARK = 8'd46;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the request word and clear the scan state
      logic scan;     // sweep the owner store
      logic wr_init;  // set up a run of writes after the sweep
      logic wr_run;   // perform the run of writes
      logic rd_one;   // read the single unit named by the request
      logic respond;  // register the response word
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       reject;
      logic       scan_done;
      logic       found;
      logic       wr_done;
   } stat_type;

endpackage

// ===== hw/rtl/cua_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module cua_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and read register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cua_ctrl.sv =====
// Controller state machine that sequences each allocator command.
`timescale 1ns / 1ps
module cua_ctrl import cua_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_DISPATCH = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_POST     = 3'd4;
   localparam logic [2:0] S_WRITE    = 3'd5;
   localparam logic [2:0] S_READ     = 3'd6;
   localparam logic [2:0] S_RESP     = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.wr_run = 1'b1;
            if (stat.wr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.op == OP_READ) begin
               state_in = S_READ;
            end else if (stat.reject) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if ((stat.op == OP_ALLOC && stat.found) || stat.op == OP_COMPACT) begin
               cmd.wr_init = 1'b1;
               state_in    = S_WRITE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WRITE: begin
            cmd.wr_run = 1'b1;
            if (stat.wr_done) begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            cmd.rd_one = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/cua_dp.sv =====
// Datapath: owner store, sweep counters, hole tracking and response registers.
`timescale 1ns / 1ps
module cua_dp import cua_pkg::*; #(
   parameter int POOL_UNITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_owner_name,
   input  logic [6:0] req_request_size,
   input  logic [1:0] req_fit_mode,
   input  logic [5:0] req_unit_index,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_start_unit,
   output logic [7:0] rsp_owner_out,
   output logic [6:0] rsp_unit_count
);

   localparam int IDX_W = $clog2(POOL_UNITS);
   localparam int CNT_W = $clog2(POOL_UNITS + 1);
   localparam int SZ_W  = (CNT_W > 7) ? CNT_W : 7;
   localparam int XW    = IDX_W + 6;

   // Captured request word.
   logic [1:0] op_ff, mode_ff;
   logic [7:0] owner_ff;
   logic [6:0] size_ff;
   logic [5:0] idx_ff;

   // Sweep state.
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             dv_ff, dv_in;
   logic [IDX_W-1:0] da_ff, da_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] run_start_ff, run_start_in;
   logic [CNT_W-1:0] run_len_ff, run_len_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   logic [CNT_W-1:0] pick_len_ff, pick_len_in;
   logic             pick_valid_ff, pick_valid_in;

   // Write run state.
   logic [CNT_W-1:0] wr_cnt_ff, wr_cnt_in;
   logic [CNT_W-1:0] wr_end_ff, wr_end_in;
   logic [7:0]       wr_val_ff, wr_val_in;

   // Response registers.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [5:0] rsp_start_ff, rsp_start_in;
   logic [7:0] rsp_owner_ff, rsp_owner_in;
   logic [6:0] rsp_count_ff, rsp_count_in;

   // RAM connections.
   logic             ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]       ram_wr_data, ram_rd_data;

   logic             scan_issue, is_free, is_last, hole_end, fits, take;
   logic [CNT_W-1:0] hole_len;
   logic [IDX_W-1:0] seg_base;
   logic             alloc_bad, oversize, read_oor, wr_done;
   logic [XW-1:0]    idx_ext;

   cua_ram #(
      .WIDTH(8),
      .DEPTH(POOL_UNITS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Request checks on the captured word.
   assign alloc_bad = (size_ff == 7'd0) || (owner_ff == FREE_MARK) || (mode_ff == FIT_NONE);
   assign oversize  = SZ_W'(size_ff) > SZ_W'(POOL_UNITS);
   assign idx_ext   = XW'(idx_ff);
   assign read_oor  = 32'(idx_ff) >= 32'(POOL_UNITS);
   assign wr_done   = (wr_cnt_ff == wr_end_ff);

   // Hole evaluation on the word returned by the sweep.
   assign scan_issue = cmd.scan && (scan_cnt_ff < CNT_W'(POOL_UNITS));
   assign is_free    = (ram_rd_data == FREE_MARK);
   assign is_last    = (da_ff == IDX_W'(POOL_UNITS - 1));
   assign hole_len   = is_free ? run_len_ff + CNT_W'(1) : run_len_ff;
   assign seg_base   = (is_free && run_len_ff == '0) ? da_ff : run_start_ff;
   assign hole_end   = (is_free && is_last) || (!is_free && run_len_ff != '0);
   assign fits       = hole_end && (SZ_W'(hole_len) >= SZ_W'(size_ff));
   assign take       = fits && (!pick_valid_ff
                              || (mode_ff == FIT_BEST && hole_len < pick_len_ff)
                              || (mode_ff == FIT_WORST && hole_len > pick_len_ff));

   // Read port selection.
   always_comb begin
      ram_rd_en   = scan_issue || cmd.rd_one;
      ram_rd_addr = cmd.rd_one ? idx_ext[IDX_W-1:0] : scan_cnt_ff[IDX_W-1:0];
   end

   // Write port selection: write runs, freeing, or compaction moves.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_cnt_ff[IDX_W-1:0];
      ram_wr_data = wr_val_ff;
      if (cmd.wr_run && !wr_done) begin
         ram_wr_en = 1'b1;
      end else if (cmd.scan && dv_ff && op_ff == OP_FREE && ram_rd_data == owner_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = da_ff;
         ram_wr_data = FREE_MARK;
      end else if (cmd.scan && dv_ff && op_ff == OP_COMPACT && !is_free) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cnt_ff[IDX_W-1:0];
         ram_wr_data = ram_rd_data;
      end
   end

   // Sweep, hole tracking and write run next values.
   always_comb begin
      scan_cnt_in   = scan_cnt_ff;
      dv_in         = scan_issue;
      da_in         = scan_cnt_ff[IDX_W-1:0];
      cnt_in        = cnt_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      pick_in       = pick_ff;
      pick_len_in   = pick_len_ff;
      pick_valid_in = pick_valid_ff;
      wr_cnt_in     = wr_cnt_ff;
      wr_end_in     = wr_end_ff;
      wr_val_in     = wr_val_ff;
      if (cmd.load) begin
         scan_cnt_in   = '0;
         dv_in         = 1'b0;
         cnt_in        = '0;
         run_len_in    = '0;
         pick_valid_in = 1'b0;
      end
      if (scan_issue) begin
         scan_cnt_in = scan_cnt_ff + CNT_W'(1);
      end
      if (cmd.scan && dv_ff) begin
         run_len_in   = is_free ? hole_len : '0;
         run_start_in = seg_base;
         if (take) begin
            pick_in       = seg_base;
            pick_len_in   = hole_len;
            pick_valid_in = 1'b1;
         end
         if ((op_ff == OP_FREE && ram_rd_data == owner_ff)
             || (op_ff == OP_COMPACT && !is_free)) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.wr_init) begin
         if (op_ff == OP_ALLOC) begin
            wr_cnt_in = CNT_W'(pick_ff);
            wr_end_in = CNT_W'(pick_ff) + CNT_W'(size_ff);
            wr_val_in = owner_ff;
         end else begin
            wr_cnt_in = cnt_ff;
            wr_end_in = CNT_W'(POOL_UNITS);
            wr_val_in = FREE_MARK;
         end
      end
      if (cmd.wr_run && !wr_done) begin
         wr_cnt_in = wr_cnt_ff + CNT_W'(1);
      end
   end

   // Response word.
   always_comb begin
      rsp_valid_in  = cmd.respond;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.respond) begin
         rsp_status_in = ST_OK;
         rsp_start_in  = '0;
         rsp_owner_in  = '0;
         rsp_count_in  = '0;
         unique case (op_ff)
            OP_ALLOC: begin
               if (alloc_bad) begin
                  rsp_status_in = ST_BAD;
               end else if (oversize || !pick_valid_ff) begin
                  rsp_status_in = ST_NOSPACE;
               end else begin
                  rsp_start_in = 6'(pick_ff);
               end
            end
            OP_FREE: begin
               if (owner_ff == FREE_MARK) begin
                  rsp_status_in = ST_BAD;
               end else begin
                  rsp_count_in = 7'(cnt_ff);
               end
            end
            OP_COMPACT: begin
               rsp_count_in = 7'(cnt_ff);
            end
            OP_READ: begin
               rsp_owner_in = read_oor ? FREE_MARK : ram_rd_data;
            end
            default: begin
               rsp_status_in = ST_BAD;
            end
         endcase
      end
   end

   // Request capture; payload only.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         owner_ff <= req_owner_name;
         size_ff  <= req_request_size;
         mode_ff  <= req_fit_mode;
         idx_ff   <= req_unit_index;
      end
   end

   // Control registers; reset arms the clearing sweep over the store.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff   <= '0;
         dv_ff         <= 1'b0;
         pick_valid_ff <= 1'b0;
         wr_cnt_ff     <= '0;
         wr_end_ff     <= CNT_W'(POOL_UNITS);
         wr_val_ff     <= FREE_MARK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scan_cnt_ff   <= scan_cnt_in;
         dv_ff         <= dv_in;
         pick_valid_ff <= pick_valid_in;
         wr_cnt_ff     <= wr_cnt_in;
         wr_end_ff     <= wr_end_in;
         wr_val_ff     <= wr_val_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers of the sweep and the response.
   always_ff @(posedge clock) begin
      da_ff         <= da_in;
      cnt_ff        <= cnt_in;
      run_start_ff  <= run_start_in;
      run_len_ff    <= run_len_in;
      pick_ff       <= pick_in;
      pick_len_ff   <= pick_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Status towards the controller.
   always_comb begin
      stat.op        = op_ff;
      stat.reject    = (op_ff == OP_ALLOC && (alloc_bad || oversize))
                    || (op_ff == OP_FREE && owner_ff == FREE_MARK);
      stat.scan_done = dv_ff && is_last;
      stat.found     = pick_valid_ff;
      stat.wr_done   = wr_done;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_start_unit = rsp_start_ff;
   assign rsp_owner_out  = rsp_owner_ff;
   assign rsp_unit_count = rsp_count_ff;

endmodule

// ===== hw/rtl/contiguous_unit_allocator.sv =====
// Top level of the contiguous unit allocator.
// A command word is taken when start is high and busy is low; its single response
// word appears for exactly one cycle with rsp_valid high and cannot be held off, so
// the receiver must capture it then. All work goes through the one-write, one-read
// owner store RAM, one unit per cycle. After reset a clearing sweep marks every unit
// free, with busy high. Read fetches the one named unit. Free frees the owner's units
// during a sweep of the store; allocate sweeps for a hole and, when one fits, writes
// its owner over it; compact sweeps, packing owned units down, then marks the rest
// free. Rejected requests answer without touching the store.
`timescale 1ns / 1ps
`include "contiguous_unit_allocator_defines.svh"
module contiguous_unit_allocator import cua_pkg::*; #(
   parameter int POOL_UNITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_owner_name,
   input  logic [6:0] req_request_size,
   input  logic [1:0] req_fit_mode,
   input  logic [5:0] req_unit_index,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_start_unit,
   output logic [7:0] rsp_owner_out,
   output logic [6:0] rsp_unit_count
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencing of each command.
   cua_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   // Owner store and the sweep logic around it.
   cua_dp #(
      .POOL_UNITS(POOL_UNITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_owner_name  (req_owner_name),
      .req_request_size(req_request_size),
      .req_fit_mode    (req_fit_mode),
      .req_unit_index  (req_unit_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_start_unit  (rsp_start_unit),
      .rsp_owner_out   (rsp_owner_out),
      .rsp_unit_count  (rsp_unit_count)
   );

   // An accepted word keeps the block busy in the next cycle.
   `CUA_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy, "not busy after accept")
   // A response strobe lasts exactly one cycle.
   `CUA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "response strobe repeated")
   // The response is only presented once the command has completed.
   `CUA_ASSERT_NOW(a_resp_when_idle, clock, reset, rsp_valid, !busy, "response while busy")
   // A failed request reports no start unit.
   `CUA_ASSERT_NOW(a_fail_no_start, clock, reset, rsp_valid && rsp_status != ST_OK,
      rsp_start_unit == 6'd0, "start unit set on failure")

endmodule
